@@ rtl/ssf_pkg.sv @@
// Shared types, constants and helpers for the stream substring finder.
`default_nettype none
package ssf_pkg;

  // Default build values for the top-level parameters
  localparam int DEF_MAX_PATTERN = 8;
  localparam int DEF_POS_BITS    = 16;

  localparam int CHAR_W    = 8;
  localparam int PAT_W     = 64;
  localparam int LEN_W     = 4;
  localparam int CNT_W     = 16;
  localparam int OUT_POS_W = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CHAR_W-1:0] LINE_FEED = 8'd10;
  localparam logic [CHAR_W-1:0] UPPER_A   = 8'd65;
  localparam logic [CHAR_W-1:0] UPPER_Z   = 8'd90;
  localparam logic [CHAR_W-1:0] CASE_OFS  = 8'd32;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_CHARS    = 3'd0,
    REG_PATTERN_LENGTH   = 3'd1,
    REG_CASE_INSENSITIVE = 3'd2,
    REG_ALLOW_LINE_SPLIT = 3'd3,
    REG_HITS_TO_SKIP     = 3'd4,
    REG_HIT_LIMIT        = 3'd5
  } ssf_reg_t;

  // Configuration as seen by the search core
  typedef struct packed {
    logic [PAT_W-1:0] pattern_chars;
    logic [LEN_W-1:0] pattern_length;
    logic             case_insensitive;
    logic             allow_line_split;
    logic [CNT_W-1:0] hits_to_skip;
    logic [CNT_W-1:0] hit_limit;
  } ssf_cfg_t;

  // One result of the search core
  typedef struct packed {
    logic                 hit;
    logic [OUT_POS_W-1:0] hit_line;
    logic [OUT_POS_W-1:0] hit_column;
    logic                 search_done;
  } ssf_result_t;

  // Fold A-Z onto a-z when case folding is on
  function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
                                                  input logic ci);
    logic [CHAR_W-1:0] r;
    r = c;
    if (ci && (c >= UPPER_A) && (c <= UPPER_Z)) begin
      r = c + CASE_OFS;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/ssf_cfg.sv @@
// Configuration register file of the stream substring finder.
`default_nettype none
module ssf_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [ssf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ssf_pkg::PAT_W-1:0]     cfg_data,
  output      ssf_pkg::ssf_cfg_t             cfg
);
  import ssf_pkg::*;

  // Writes are always taken
  assign cfg_ready = 1'b1;

  // Update the addressed register on each write transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_chars    <= '0;
      cfg.pattern_length   <= LEN_W'(1);
      cfg.case_insensitive <= 1'b0;
      cfg.allow_line_split <= 1'b0;
      cfg.hits_to_skip     <= '0;
      cfg.hit_limit        <= CNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PATTERN_CHARS:    cfg.pattern_chars    <= cfg_data;
        REG_PATTERN_LENGTH:   cfg.pattern_length   <= cfg_data[LEN_W-1:0];
        REG_CASE_INSENSITIVE: cfg.case_insensitive <= cfg_data[0];
        REG_ALLOW_LINE_SPLIT: cfg.allow_line_split <= cfg_data[0];
        REG_HITS_TO_SKIP:     cfg.hits_to_skip     <= cfg_data[CNT_W-1:0];
        REG_HIT_LIMIT:        cfg.hit_limit        <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/ssf_core.sv @@
// Search state and combinational step logic of the stream substring finder.
`default_nettype none
module ssf_core #(
  parameter int MAX_PATTERN = ssf_pkg::DEF_MAX_PATTERN,
  parameter int POS_BITS    = ssf_pkg::DEF_POS_BITS
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       step,
  input  wire logic [ssf_pkg::CHAR_W-1:0] text_char,
  input  wire logic                       restart,
  input  wire ssf_pkg::ssf_cfg_t          cfg,
  output      ssf_pkg::ssf_result_t       result
);
  import ssf_pkg::*;

  localparam logic [LEN_W-1:0]    MAX_LEN = LEN_W'(MAX_PATTERN);
  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  // State registers
  logic [LEN_W-1:0]    match_index, match_index_next;
  logic                cand_valid, cand_valid_next;
  logic [POS_BITS-1:0] cand_line, cand_line_next;
  logic [POS_BITS-1:0] cand_column, cand_column_next;
  logic [POS_BITS-1:0] cur_line, cur_line_next;
  logic [POS_BITS-1:0] cur_column, cur_column_next;
  logic [CNT_W-1:0]    skipped_count, skipped_count_next;
  logic [CNT_W-1:0]    reported_count, reported_count_next;
  logic                finished, finished_next;

  logic [LEN_W-1:0]           len;
  logic [CHAR_W-1:0]          pat_char;
  logic                       matched;
  logic                       line_split;
  logic                       hit;
  logic [POS_BITS+OUT_POS_W-1:0] line_ext;
  logic [POS_BITS+OUT_POS_W-1:0] column_ext;

  // Effective pattern length, capped at the pattern storage
  assign len = (cfg.pattern_length > MAX_LEN) ? MAX_LEN : cfg.pattern_length;

  assign line_split = (text_char == LINE_FEED) && cfg.allow_line_split;

  // Compute the state after this character
  always_comb begin
    match_index_next    = match_index;
    cand_valid_next     = cand_valid;
    cand_line_next      = cand_line;
    cand_column_next    = cand_column;
    cur_line_next       = cur_line;
    cur_column_next     = cur_column;
    skipped_count_next  = skipped_count;
    reported_count_next = reported_count;
    finished_next       = finished;
    pat_char            = '0;
    matched             = 1'b0;
    hit                 = 1'b0;

    // Clear the search state on a restart flag
    if (restart) begin
      match_index_next    = '0;
      cand_valid_next     = 1'b0;
      cand_line_next      = '0;
      cand_column_next    = '0;
      cur_line_next       = '0;
      cur_column_next     = '0;
      skipped_count_next  = '0;
      reported_count_next = '0;
      finished_next       = 1'b0;
    end
    if (cfg.hit_limit == '0) begin
      finished_next = 1'b1;
    end

    if (!finished_next) begin
      // Drop a match that outran a shortened pattern
      if (match_index_next >= len) begin
        match_index_next = '0;
        cand_valid_next  = 1'b0;
      end
      pat_char = cfg.pattern_chars[{match_index_next[2:0], 3'b000} +: CHAR_W];
      matched  = (len != '0) &&
                 (fold_char(text_char, cfg.case_insensitive) ==
                  fold_char(pat_char, cfg.case_insensitive));

      // Advance or restart the match
      if (matched) begin
        if (!cand_valid_next) begin
          cand_valid_next  = 1'b1;
          cand_line_next   = cur_line_next;
          cand_column_next = cur_column_next;
        end
        match_index_next = match_index_next + LEN_W'(1);
      end else if (!line_split) begin
        cand_valid_next  = 1'b0;
        match_index_next = '0;
      end

      // Count or report a completed match
      if ((len != '0) && (match_index_next == len)) begin
        if (skipped_count_next == cfg.hits_to_skip) begin
          hit                 = 1'b1;
          reported_count_next = reported_count_next + CNT_W'(1);
        end else begin
          skipped_count_next = skipped_count_next + CNT_W'(1);
        end
        if (reported_count_next == cfg.hit_limit) begin
          finished_next = 1'b1;
        end
        cand_valid_next  = 1'b0;
        match_index_next = '0;
      end

      // Track line and column, saturating
      if (!finished_next) begin
        if (text_char == LINE_FEED) begin
          cur_line_next   = (cur_line_next == POS_MAX) ? POS_MAX
                                                       : cur_line_next + POS_BITS'(1);
          cur_column_next = '0;
        end else begin
          cur_column_next = (cur_column_next == POS_MAX) ? POS_MAX
                                                         : cur_column_next + POS_BITS'(1);
        end
      end
    end
  end

  // Fit the start position onto the 16-bit result fields
  assign line_ext   = {{OUT_POS_W{1'b0}}, cand_line_next};
  assign column_ext = {{OUT_POS_W{1'b0}}, cand_column_next};

  assign result.hit         = hit;
  assign result.hit_line    = hit ? line_ext[OUT_POS_W-1:0] : '0;
  assign result.hit_column  = hit ? column_ext[OUT_POS_W-1:0] : '0;
  assign result.search_done = finished_next;

  // Commit the new state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      match_index    <= '0;
      cand_valid     <= 1'b0;
      cand_line      <= '0;
      cand_column    <= '0;
      cur_line       <= '0;
      cur_column     <= '0;
      skipped_count  <= '0;
      reported_count <= '0;
      finished       <= 1'b0;
    end else if (step) begin
      match_index    <= match_index_next;
      cand_valid     <= cand_valid_next;
      cand_line      <= cand_line_next;
      cand_column    <= cand_column_next;
      cur_line       <= cur_line_next;
      cur_column     <= cur_column_next;
      skipped_count  <= skipped_count_next;
      reported_count <= reported_count_next;
      finished       <= finished_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/stream_substring_finder_top.sv @@
// Top level of the stream substring finder: config port, search core, result register.
`default_nettype none
// Searches a character stream for a configured pattern of up to MAX_PATTERN
// characters, with optional ASCII case folding and optional line feeds inside
// a match. Each accepted character yields exactly one result transaction that
// carries the hit flag, the start line and column of a reported hit, and the
// done flag. One character is taken every clock cycle: the whole search step
// is one stage of logic from the state registers into the result register,
// so each result is registered as its character is taken, and input is stalled
// only while a held result is not taken. Configuration writes are taken at
// once and must be made while no result is outstanding.
module stream_substring_finder_top #(
  parameter int MAX_PATTERN = ssf_pkg::DEF_MAX_PATTERN,
  parameter int POS_BITS    = ssf_pkg::DEF_POS_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Configuration write channel
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [ssf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ssf_pkg::PAT_W-1:0]     cfg_data,
  // Character stream in
  input  wire logic                          s_tvalid,
  output      logic                          s_tready,
  input  wire logic [7:0]                    s_tdata,   // [7:0] text_char
  input  wire logic                          s_tuser,   // [0] restart
  // Result stream out
  output      logic                          m_tvalid,
  input  wire logic                          m_tready,
  output      logic [31:0]                   m_tdata,   // [15:0] hit_line, [31:16] hit_column
  output      logic [1:0]                    m_tuser    // [0] hit, [1] search_done
);
  import ssf_pkg::*;

  ssf_cfg_t    cfg;
  ssf_result_t result;
  logic        step;

  ssf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Take a character whenever the result register is free or being drained
  assign s_tready = !m_tvalid || m_tready;
  assign step     = s_tvalid && s_tready;

  ssf_core #(
    .MAX_PATTERN (MAX_PATTERN),
    .POS_BITS    (POS_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .text_char (s_tdata),
    .restart   (s_tuser),
    .cfg       (cfg),
    .result    (result)
  );

  // Hold the result until the downstream side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= {result.hit_column, result.hit_line};
      m_tuser <= {result.search_done, result.hit};
    end
  end

endmodule
`default_nettype wire

@@ tb/sv/stream_substring_finder_checker.sv @@
// Checker for the stream substring finder: tracks the search and compares every result.
module stream_substring_finder_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [ssf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ssf_pkg::PAT_W-1:0]     cfg_data,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] text_char
  input  logic                          s_tuser,   // [0] restart
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [31:0]                   m_tdata,   // [15:0] hit_line, [31:16] hit_column
  input  logic [1:0]                    m_tuser,   // [0] hit, [1] search_done
  output int                            fail_count,
  output int                            outstanding,
  output int                            results_seen,
  output int                            hits_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import ssf_pkg::*;

  localparam int MAX_PAT = 8;
  localparam logic [15:0] POS_TOP = 16'hFFFF;

  localparam ssf_cfg_t CFG_AT_RESET = '{
    pattern_chars: '0, pattern_length: 4'd1, case_insensitive: 1'b0,
    allow_line_split: 1'b0, hits_to_skip: '0, hit_limit: 16'd1
  };

  typedef struct packed {
    logic [3:0]  pos_in_pattern;
    logic        cand;
    logic [15:0] cand_line;
    logic [15:0] cand_col;
    logic [15:0] line;
    logic [15:0] col;
    logic [15:0] skipped;
    logic [15:0] reported;
    logic        done;
  } finder_state_t;

  ssf_cfg_t      shadow_cfg = CFG_AT_RESET;
  finder_state_t track = '0;
  ssf_result_t   pending_results[$];
  ssf_result_t   want;
  ssf_result_t   got;
  int            errors = 0;
  int            n_results = 0;
  int            n_hits = 0;

  // Fold A-Z onto a-z when folding is on
  function automatic logic [7:0] casefold(input logic [7:0] c, input logic on);
    if (on && c >= 8'd65 && c <= 8'd90) begin
      return c + 8'd32;
    end
    return c;
  endfunction

  // Advance the search by one character and return the result it yields
  function automatic ssf_result_t advance_search(input logic [7:0] ch, input logic clear);
    ssf_result_t r;
    logic [3:0]  len;
    logic [7:0]  pc;
    logic        matched;
    r = '0;
    len = (shadow_cfg.pattern_length > 4'(MAX_PAT)) ? 4'(MAX_PAT)
                                                    : shadow_cfg.pattern_length;
    if (clear) begin
      track = '0;
    end
    if (shadow_cfg.hit_limit == '0) begin
      track.done = 1'b1;
    end
    if (!track.done) begin
      matched = 1'b0;
      // drop a match that no longer fits a shortened pattern
      if (track.pos_in_pattern >= len) begin
        track.pos_in_pattern = '0;
        track.cand = 1'b0;
      end
      if (len != '0) begin
        pc = shadow_cfg.pattern_chars[{track.pos_in_pattern[2:0], 3'b000} +: 8];
        matched = casefold(ch, shadow_cfg.case_insensitive) ==
                  casefold(pc, shadow_cfg.case_insensitive);
      end
      if (matched) begin
        if (!track.cand) begin
          track.cand = 1'b1;
          track.cand_line = track.line;
          track.cand_col = track.col;
        end
        track.pos_in_pattern = track.pos_in_pattern + 4'd1;
      end else if (!(ch == LINE_FEED && shadow_cfg.allow_line_split)) begin
        track.cand = 1'b0;
        track.pos_in_pattern = '0;
      end
      // complete match: skip or report
      if (len != '0 && track.pos_in_pattern == len) begin
        if (track.skipped == shadow_cfg.hits_to_skip) begin
          r.hit = 1'b1;
          r.hit_line = track.cand_line;
          r.hit_column = track.cand_col;
          track.reported = track.reported + 16'd1;
        end else begin
          track.skipped = track.skipped + 16'd1;
        end
        if (track.reported == shadow_cfg.hit_limit) begin
          track.done = 1'b1;
        end
        track.cand = 1'b0;
        track.pos_in_pattern = '0;
      end
      // advance the position, saturating
      if (!track.done) begin
        if (ch == LINE_FEED) begin
          if (track.line != POS_TOP) track.line = track.line + 16'd1;
          track.col = '0;
        end else if (track.col != POS_TOP) begin
          track.col = track.col + 16'd1;
        end
      end
    end
    r.search_done = track.done;
    return r;
  endfunction

  function automatic void flag_error(input string what, input int exp_v, input int act_v);
    if (errors < 10) begin
      $display("result %0d: %s expected %0d got %0d", n_results, what, exp_v, act_v);
    end
    errors++;
  endfunction

  // Watch all three channels at each edge
  always @(posedge clk) begin
    if (rst) begin
      shadow_cfg = CFG_AT_RESET;
      track = '0;
      pending_results.delete();
    end else begin
      // compare a result transaction with the oldest expectation
      if (m_tvalid && m_tready) begin
        got.hit = m_tuser[0];
        got.search_done = m_tuser[1];
        got.hit_line = m_tdata[15:0];
        got.hit_column = m_tdata[31:16];
        n_results++;
        if (got.hit) n_hits++;
        if (pending_results.size() == 0) begin
          flag_error("unexpected result, pending count", 0, 1);
        end else begin
          want = pending_results.pop_front();
          if (got.hit != want.hit) flag_error("hit", want.hit, got.hit);
          if (got.hit_line != want.hit_line) flag_error("hit_line", want.hit_line, got.hit_line);
          if (got.hit_column != want.hit_column)
            flag_error("hit_column", want.hit_column, got.hit_column);
          if (got.search_done != want.search_done)
            flag_error("search_done", want.search_done, got.search_done);
        end
      end
      // apply a register write
      if (cfg_valid && cfg_ready) begin
        case (ssf_reg_t'(cfg_index))
          REG_PATTERN_CHARS:    shadow_cfg.pattern_chars = cfg_data;
          REG_PATTERN_LENGTH:   shadow_cfg.pattern_length = cfg_data[3:0];
          REG_CASE_INSENSITIVE: shadow_cfg.case_insensitive = cfg_data[0];
          REG_ALLOW_LINE_SPLIT: shadow_cfg.allow_line_split = cfg_data[0];
          REG_HITS_TO_SKIP:     shadow_cfg.hits_to_skip = cfg_data[15:0];
          REG_HIT_LIMIT:        shadow_cfg.hit_limit = cfg_data[15:0];
          default: ;
        endcase
      end
      // predict the result of a character transaction
      if (s_tvalid && s_tready) begin
        pending_results.push_back(advance_search(s_tdata, s_tuser));
      end
    end
    fail_count <= errors;
    outstanding <= pending_results.size();
    results_seen <= n_results;
    hits_seen <= n_hits;
  end

endmodule

@@ tb/sv/tb_stream_substring_finder_top.sv @@
// Testbench top for the stream substring finder: clock, reset, stimulus and verdict.
module tb_stream_substring_finder_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ssf_pkg::*;

  localparam int CYCLE_LIMIT = 50000;
  localparam ssf_reg_t REG_ORDER [6] = '{
    REG_PATTERN_CHARS, REG_PATTERN_LENGTH, REG_CASE_INSENSITIVE,
    REG_ALLOW_LINE_SPLIT, REG_HITS_TO_SKIP, REG_HIT_LIMIT
  };

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PAT_W-1:0]     cfg_data;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [7:0]           s_tdata;   // [7:0] text_char
  logic                 s_tuser;   // [0] restart
  logic                 m_tvalid;
  logic                 m_tready;
  logic [31:0]          m_tdata;   // [15:0] hit_line, [31:16] hit_column
  logic [1:0]           m_tuser;   // [0] hit, [1] search_done

  int       fail_count;
  int       outstanding;
  int       results_seen;
  int       hits_seen;
  int       cycle_count = 0;
  int       chars_sent = 0;
  bit       tx_idle = 1'b1;
  bit       rx_idle = 1'b1;
  ssf_cfg_t search_cfg;

  stream_substring_finder_top DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  stream_substring_finder_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .fail_count(fail_count), .outstanding(outstanding),
    .results_seen(results_seen), .hits_seen(hits_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[stream_substring_finder_top] ERROR");
      $finish;
    end
  end

  // Result side: drop ready at random before each transaction while rx_idle is set
  initial begin
    int stall;
    forever begin
      stall = rx_idle ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Send one character transaction after a random gap; valid stays high
  task automatic put_char(input logic [7:0] ch, input logic clear);
    int gap;
    gap = tx_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= ch;
    s_tuser <= clear;
    do @(posedge clk); while (!s_tready);
    chars_sent++;
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) begin
      put_char(txt[i], 1'b0);
    end
  endtask

  // Stop sending and wait until every result is back
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (2) @(posedge clk);
  endtask

  // Write all six registers back to back
  task automatic load_setup(input ssf_cfg_t c);
    logic [63:0] vals [6];
    vals[0] = c.pattern_chars;
    vals[1] = 64'(c.pattern_length);
    vals[2] = 64'(c.case_insensitive);
    vals[3] = 64'(c.allow_line_split);
    vals[4] = 64'(c.hits_to_skip);
    vals[5] = 64'(c.hit_limit);
    for (int r = 0; r < 6; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= REG_ORDER[r];
      cfg_data <= vals[r];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    search_cfg = c;
  endtask

  // Flip the case of a letter at random while folding is on
  function automatic logic [7:0] vary_case(input logic [7:0] c);
    if (search_cfg.case_insensitive && $urandom_range(0, 1) == 1 &&
        ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z"))) begin
      return c ^ 8'h20;
    end
    return c;
  endfunction

  function automatic logic [7:0] pattern_byte();
    case ($urandom_range(0, 7))
      0: return 8'($urandom_range(0, 255));
      1: return LINE_FEED;
      2: return "A";
      3: return "B";
      4: return "b";
      default: return "a";
    endcase
  endfunction

  function automatic logic [7:0] stray_char();
    case ($urandom_range(0, 4))
      0: return 8'($urandom_range(0, 255));
      1: return LINE_FEED;
      default: return vary_case(search_cfg.pattern_chars[$urandom_range(0, 7) * 8 +: 8]);
    endcase
  endfunction

  function automatic ssf_cfg_t random_setup();
    ssf_cfg_t c;
    for (int i = 0; i < 8; i++) c.pattern_chars[i * 8 +: 8] = pattern_byte();
    case ($urandom_range(0, 9))
      0: c.pattern_length = 4'd0;
      1: c.pattern_length = 4'($urandom_range(9, 15));
      2, 3, 4: c.pattern_length = 4'($urandom_range(1, 8));
      default: c.pattern_length = 4'($urandom_range(1, 4));
    endcase
    c.case_insensitive = 1'($urandom_range(0, 1));
    c.allow_line_split = 1'($urandom_range(0, 1));
    c.hits_to_skip = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0: c.hit_limit = 16'd0;
      1, 2: c.hit_limit = 16'hFFFF;
      default: c.hit_limit = 16'($urandom_range(1, 8));
    endcase
    return c;
  endfunction

  // Mostly whole pattern occurrences, some cut short, some noise
  task automatic random_text(input int count);
    int len;
    int cut;
    int sent;
    len = (search_cfg.pattern_length > 4'd8) ? 8 : int'(search_cfg.pattern_length);
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: cut = len;
        6, 7: cut = (len > 0) ? $urandom_range(0, len - 1) : 0;
        default: cut = -1;
      endcase
      for (int k = 0; k < cut; k++) begin
        if (search_cfg.allow_line_split && $urandom_range(0, 5) == 0) begin
          put_char(LINE_FEED, sent == 0 || $urandom_range(0, 39) == 0);
          sent++;
        end
        put_char(vary_case(search_cfg.pattern_chars[k * 8 +: 8]),
                 sent == 0 || $urandom_range(0, 39) == 0);
        sent++;
      end
      if (cut < len || len == 0) begin
        repeat ($urandom_range(1, 3)) begin
          put_char(stray_char(), sent == 0 || $urandom_range(0, 39) == 0);
          sent++;
        end
      end
    end
  endtask

  initial begin
    ssf_cfg_t setup;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= 1'b0;
    search_cfg = '{pattern_chars: '0, pattern_length: 4'd1, case_insensitive: 1'b0,
                   allow_line_split: 1'b0, hits_to_skip: '0, hit_limit: 16'd1};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset registers: NUL pattern, one hit, then ignored until restart
    put_char(8'h00, 1'b0);
    put_char(8'hFF, 1'b0);
    put_char(8'hFF, 1'b1);
    put_char(8'h00, 1'b0);
    drain();

    // Folding, line feed inside a match, naive restart, skip one, stop after two
    setup = '{pattern_chars: 64'h0000_0000_0063_4261, pattern_length: 4'd3,
              case_insensitive: 1'b1, allow_line_split: 1'b1,
              hits_to_skip: 16'd1, hit_limit: 16'd2};
    load_setup(setup);
    put_char("x", 1'b1);
    send_text("abcA\nBCaabcABCa");
    drain();

    // Oversized length saturates to eight, pattern holds 00 and FF
    setup = '{pattern_chars: 64'hFF00_7A41_0A62_5A61, pattern_length: 4'd15,
              case_insensitive: 1'b0, allow_line_split: 1'b0,
              hits_to_skip: 16'd0, hit_limit: 16'hFFFF};
    load_setup(setup);
    for (int i = 0; i < 8; i++) put_char(setup.pattern_chars[i * 8 +: 8], i == 0);
    for (int i = 0; i < 3; i++) put_char(setup.pattern_chars[i * 8 +: 8], 1'b0);
    drain();

    // Shorten the pattern in the middle of a match
    setup.pattern_length = 4'd2;
    load_setup(setup);
    put_char(setup.pattern_chars[7:0], 1'b0);
    put_char(setup.pattern_chars[15:8], 1'b0);
    drain();

    // Empty pattern never matches; then a zero hit limit stops at once
    setup.pattern_length = 4'd0;
    setup.hits_to_skip = 16'hFFFF;
    load_setup(setup);
    send_text("aZ");
    drain();
    setup.hit_limit = 16'd0;
    load_setup(setup);
    put_char("a", 1'b0);
    drain();

    // Random settings and text, idling varied per phase
    for (int ph = 0; ph < 8; ph++) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      load_setup(random_setup());
      random_text(70);
      drain();
    end

    $display("Sent %0d characters and checked %0d results, %0d of them reported hits,",
             chars_sent, results_seen, hits_seen);
    $display("over reset, directed and random register settings.");
    if (fail_count == 0 && outstanding == 0) begin
      $display("[stream_substring_finder_top] OK");
    end else begin
      $display("[stream_substring_finder_top] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ssf_pkg.sv
rtl/ssf_cfg.sv
rtl/ssf_core.sv
rtl/stream_substring_finder_top.sv
tb/sv/stream_substring_finder_checker.sv
tb/sv/tb_stream_substring_finder_top.sv
